// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the route table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define DVRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DVRT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dvrt_pkg.sv =====
// types, constants and helpers of the distance vector route table
package dvrt_pkg;

   localparam int ROUTE_ENTRIES    = 64;
   localparam int NEIGHBOR_ENTRIES = 16;
   localparam int RIDX_W = $clog2(ROUTE_ENTRIES);
   localparam int NIDX_W = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;

   localparam logic [15:0] COST_INF = 16'hFFFF;

   localparam logic [1:0] ACT_VECTOR    = 2'd0;
   localparam logic [1:0] ACT_LINK_COST = 2'd1;
   localparam logic [1:0] ACT_LINK_DOWN = 2'd2;
   localparam logic [1:0] ACT_LOOKUP    = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] neighbor_id;
      logic [15:0] node_id;
      logic [15:0] cost;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] next_hop;
      logic [15:0] path_cost;
      logic        changed;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic [15:0] dest;
      logic [15:0] cost;
      logic [15:0] hop;
   } route_entry_type;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? COST_INF : s[15:0];
   endfunction

endpackage

// ===== rtl/core/dvrt_route_mem.sv =====
// route entry store, one write and one registered read port
module dvrt_route_mem (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [dvrt_pkg::RIDX_W-1:0]          waddr,
   input  dvrt_pkg::route_entry_type            wdata,
   input  logic [dvrt_pkg::RIDX_W-1:0]          raddr,
   output dvrt_pkg::route_entry_type            rdata
);

   dvrt_pkg::route_entry_type mem [dvrt_pkg::ROUTE_ENTRIES];
   dvrt_pkg::route_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/distance_vector_route_table_core.sv =====
// distance vector route table: neighbour costs, routes and a sweep sequencer
//
// channel   direction  handshake                     payload
// req       in         start high while busy low     req_data (dvrt_pkg::req_type)
// rsp       out        rsp_valid, one cycle          rsp_data (dvrt_pkg::rsp_type)
// csr       in/out     psel, penable, pwrite, pready own_router_id at byte 0
//
// one transaction at a time; busy stays high until its response is shown
// work is done in sweeps of the single route memory read port, one entry per cycle:
// a lookup sweeps once, a vector entry from a known neighbour once, plus a purge sweep on a last entry,
// link items once per valid neighbour, then once more to drop routes whose hop is no valid neighbour
// synchronous reset clears control state and the valid bits; the receiver cannot stall
`include "assert_macros.svh"

module distance_vector_route_table_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dvrt_pkg::req_type   req_data,
   output logic                rsp_valid,
   output dvrt_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int RW = dvrt_pkg::RIDX_W;
   localparam int NW = dvrt_pkg::NIDX_W;
   localparam int NE = dvrt_pkg::NEIGHBOR_ENTRIES;
   localparam int RE = dvrt_pkg::ROUTE_ENTRIES;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_NB_SCAN = 4'd1;
   localparam logic [3:0] S_RT_SCAN = 4'd2;
   localparam logic [3:0] S_VEC_UPD = 4'd3;
   localparam logic [3:0] S_VEC_END = 4'd4;
   localparam logic [3:0] S_PURGE   = 4'd5;
   localparam logic [3:0] S_VEC_FIN = 4'd6;
   localparam logic [3:0] S_REC_NB  = 4'd7;
   localparam logic [3:0] S_REC_UPD = 4'd8;
   localparam logic [3:0] S_DROP    = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [15:0] own_id_ff, own_id_in;
   logic [RE-1:0] rvalid_ff, rvalid_in, seen_ff, seen_in;
   logic [NE-1:0] nvalid_ff, nvalid_in;
   logic [15:0] nkey_ff [NE];
   logic [15:0] nkey_in [NE];
   logic [15:0] ncost_ff [NE];
   logic [15:0] ncost_in [NE];
   logic        vchg_ff, vchg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   dvrt_pkg::rsp_type rsp_ff, rsp_in;
   dvrt_pkg::req_type req_ff, req_in;

   logic [RW:0]   cnt_ff, cnt_in;
   logic          pv_ff, pv_in;
   logic [RW-1:0] pidx_ff, pidx_in;
   logic [NW:0]   ncnt_ff, ncnt_in;
   logic [NW:0]   rec_ff, rec_in;
   logic          nhit_ff, nhit_in, nfree_ok_ff, nfree_ok_in;
   logic [NW-1:0] nidx_ff, nidx_in, nfree_ff, nfree_in;
   logic          rhit_ff, rhit_in, rfree_ok_ff, rfree_ok_in;
   logic [RW-1:0] ridx_ff, ridx_in, rfree_ff, rfree_in;
   logic [15:0]   rcost_ff, rcost_in, rhop_ff, rhop_in;
   logic [15:0]   key_ff, key_in, kcost_ff, kcost_in;
   logic          chg_ff, chg_in, full_ff, full_in;

   logic                      mem_we;
   logic [RW-1:0]             mem_waddr;
   dvrt_pkg::route_entry_type mem_wdata, mem_q;

   logic          rd_act, sweep_end, nb_any, skip;
   logic [15:0]   nc;
   logic [NW-1:0] n_sel, rec_sel;

   dvrt_route_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (cnt_ff[RW-1:0]),
      .rdata (mem_q)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? {16'h0000, own_id_ff} : 32'h0000_0000;

   always_comb begin
      own_id_in    = own_id_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         own_id_in = pwdata[15:0];
      end
      state_in     = state_ff;
      rvalid_in    = rvalid_ff;
      seen_in      = seen_ff;
      nvalid_in    = nvalid_ff;
      nkey_in      = nkey_ff;
      ncost_in     = ncost_ff;
      vchg_in      = vchg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      ncnt_in      = ncnt_ff;
      rec_in       = rec_ff;
      nhit_in      = nhit_ff;
      nfree_ok_in  = nfree_ok_ff;
      nidx_in      = nidx_ff;
      nfree_in     = nfree_ff;
      rhit_in      = rhit_ff;
      rfree_ok_in  = rfree_ok_ff;
      ridx_in      = ridx_ff;
      rfree_in     = rfree_ff;
      rcost_in     = rcost_ff;
      rhop_in      = rhop_ff;
      key_in       = key_ff;
      kcost_in     = kcost_ff;
      chg_in       = chg_ff;
      full_in      = full_ff;
      mem_we       = 1'b0;
      mem_waddr    = ridx_ff;
      mem_wdata    = '0;

      rd_act    = (cnt_ff < (RW+1)'(RE));
      sweep_end = !rd_act && !pv_ff;
      pv_in     = ((state_ff == S_RT_SCAN) || (state_ff == S_PURGE) || (state_ff == S_DROP))
                  && rd_act;
      pidx_in   = cnt_ff[RW-1:0];
      n_sel     = ncnt_ff[NW-1:0];
      rec_sel   = rec_ff[NW-1:0];

      nb_any = 1'b0;
      for (int i = 0; i < NE; i++) begin
         nb_any = nb_any | (nvalid_ff[i] && (nkey_ff[i] == mem_q.hop));
      end

      nc   = dvrt_pkg::sat_add(ncost_ff[nidx_ff], req_ff.cost);
      skip = (req_ff.node_id == own_id_ff) || (req_ff.cost == dvrt_pkg::COST_INF);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_data;
               chg_in      = 1'b0;
               full_in     = 1'b0;
               nhit_in     = 1'b0;
               nfree_ok_in = 1'b0;
               ncnt_in     = '0;
               key_in      = req_data.node_id;
               cnt_in      = '0;
               rhit_in     = 1'b0;
               rfree_ok_in = 1'b0;
               if (req_data.action == dvrt_pkg::ACT_LOOKUP) begin
                  state_in = S_RT_SCAN;
               end else begin
                  state_in = S_NB_SCAN;
               end
            end
         end
         S_NB_SCAN: begin
            if (ncnt_ff == (NW+1)'(NE)) begin
               case (req_ff.action)
                  dvrt_pkg::ACT_VECTOR: begin
                     if (nhit_ff) begin
                        state_in = S_RT_SCAN;
                     end else begin
                        state_in = S_VEC_END;
                     end
                  end
                  dvrt_pkg::ACT_LINK_COST: begin
                     if (nhit_ff) begin
                        ncost_in[nidx_ff] = req_ff.cost;
                     end else if (nfree_ok_ff) begin
                        nvalid_in[nfree_ff] = 1'b1;
                        nkey_in[nfree_ff]   = req_ff.neighbor_id;
                        ncost_in[nfree_ff]  = req_ff.cost;
                     end else begin
                        full_in = 1'b1;
                     end
                     rec_in   = '0;
                     state_in = S_REC_NB;
                  end
                  default: begin
                     if (nhit_ff) begin
                        nvalid_in[nidx_ff] = 1'b0;
                     end
                     rec_in   = '0;
                     state_in = S_REC_NB;
                  end
               endcase
            end else begin
               if (nvalid_ff[n_sel] && (nkey_ff[n_sel] == req_ff.neighbor_id) && !nhit_ff) begin
                  nhit_in = 1'b1;
                  nidx_in = n_sel;
               end
               if (!nvalid_ff[n_sel] && !nfree_ok_ff) begin
                  nfree_ok_in = 1'b1;
                  nfree_in    = n_sel;
               end
               ncnt_in = ncnt_ff + 1'b1;
            end
         end
         S_RT_SCAN: begin
            if (pv_ff) begin
               if (rvalid_ff[pidx_ff] && (mem_q.dest == key_ff) && !rhit_ff) begin
                  rhit_in  = 1'b1;
                  ridx_in  = pidx_ff;
                  rcost_in = mem_q.cost;
                  rhop_in  = mem_q.hop;
               end
               if (!rvalid_ff[pidx_ff] && !rfree_ok_ff) begin
                  rfree_ok_in = 1'b1;
                  rfree_in    = pidx_ff;
               end
            end
            if (sweep_end) begin
               case (req_ff.action)
                  dvrt_pkg::ACT_VECTOR: state_in = S_VEC_UPD;
                  dvrt_pkg::ACT_LOOKUP: state_in = S_DONE;
                  default:              state_in = S_REC_UPD;
               endcase
            end else if (rd_act) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_VEC_UPD: begin
            if (!skip) begin
               if (!rhit_ff) begin
                  if (rfree_ok_ff) begin
                     mem_we              = 1'b1;
                     mem_waddr           = rfree_ff;
                     mem_wdata           = '{dest: req_ff.node_id, cost: nc,
                                             hop: req_ff.neighbor_id};
                     rvalid_in[rfree_ff] = 1'b1;
                     seen_in[rfree_ff]   = 1'b1;
                     vchg_in             = 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end else if ((nc < rcost_ff) ||
                            ((nc > rcost_ff) && (rhop_ff == req_ff.neighbor_id))) begin
                  mem_we    = 1'b1;
                  mem_waddr = ridx_ff;
                  mem_wdata = '{dest: req_ff.node_id, cost: nc, hop: req_ff.neighbor_id};
                  vchg_in   = 1'b1;
               end
            end
            if (rhit_ff) begin
               seen_in[ridx_ff] = 1'b1;
            end
            state_in = S_VEC_END;
         end
         S_VEC_END: begin
            if (!req_ff.last) begin
               state_in = S_DONE;
            end else if (nhit_ff) begin
               cnt_in   = '0;
               state_in = S_PURGE;
            end else begin
               state_in = S_VEC_FIN;
            end
         end
         S_PURGE: begin
            if (pv_ff && rvalid_ff[pidx_ff] && (mem_q.hop == req_ff.neighbor_id) &&
                (mem_q.dest != req_ff.neighbor_id) && !seen_ff[pidx_ff]) begin
               rvalid_in[pidx_ff] = 1'b0;
               vchg_in            = 1'b1;
            end
            if (sweep_end) begin
               state_in = S_VEC_FIN;
            end else if (rd_act) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_VEC_FIN: begin
            chg_in   = vchg_ff;
            vchg_in  = 1'b0;
            seen_in  = '0;
            state_in = S_DONE;
         end
         S_REC_NB: begin
            if (rec_ff == (NW+1)'(NE)) begin
               cnt_in   = '0;
               state_in = S_DROP;
            end else if (nvalid_ff[rec_sel]) begin
               key_in      = nkey_ff[rec_sel];
               kcost_in    = ncost_ff[rec_sel];
               cnt_in      = '0;
               rhit_in     = 1'b0;
               rfree_ok_in = 1'b0;
               state_in    = S_RT_SCAN;
            end else begin
               rec_in = rec_ff + 1'b1;
            end
         end
         S_REC_UPD: begin
            if (rhit_ff) begin
               if (rcost_ff > kcost_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = ridx_ff;
                  mem_wdata = '{dest: key_ff, cost: kcost_ff, hop: key_ff};
                  chg_in    = 1'b1;
               end
            end else if (rfree_ok_ff) begin
               mem_we              = 1'b1;
               mem_waddr           = rfree_ff;
               mem_wdata           = '{dest: key_ff, cost: kcost_ff, hop: key_ff};
               rvalid_in[rfree_ff] = 1'b1;
               seen_in[rfree_ff]   = 1'b0;
               chg_in              = 1'b1;
            end else begin
               full_in = 1'b1;
            end
            rec_in   = rec_ff + 1'b1;
            state_in = S_REC_NB;
         end
         S_DROP: begin
            if (pv_ff && rvalid_ff[pidx_ff] && !nb_any) begin
               rvalid_in[pidx_ff] = 1'b0;
               seen_in[pidx_ff]   = 1'b0;
               chg_in             = 1'b1;
            end
            if (sweep_end) begin
               state_in = S_DONE;
            end else if (rd_act) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            if ((req_ff.action == dvrt_pkg::ACT_LOOKUP) && rhit_ff) begin
               rsp_in.found     = 1'b1;
               rsp_in.next_hop  = rhop_ff;
               rsp_in.path_cost = rcost_ff;
            end else begin
               rsp_in.found     = 1'b0;
               rsp_in.next_hop  = '0;
               rsp_in.path_cost = '0;
            end
            rsp_in.changed    = chg_ff;
            rsp_in.table_full = full_ff;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         own_id_ff    <= '0;
         rvalid_ff    <= '0;
         seen_ff      <= '0;
         nvalid_ff    <= '0;
         vchg_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_id_ff    <= own_id_in;
         rvalid_ff    <= rvalid_in;
         seen_ff      <= seen_in;
         nvalid_ff    <= nvalid_in;
         vchg_ff      <= vchg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nkey_ff     <= nkey_in;
      ncost_ff    <= ncost_in;
      rsp_ff      <= rsp_in;
      req_ff      <= req_in;
      cnt_ff      <= cnt_in;
      pv_ff       <= pv_in;
      pidx_ff     <= pidx_in;
      ncnt_ff     <= ncnt_in;
      rec_ff      <= rec_in;
      nhit_ff     <= nhit_in;
      nfree_ok_ff <= nfree_ok_in;
      nidx_ff     <= nidx_in;
      nfree_ff    <= nfree_in;
      rhit_ff     <= rhit_in;
      rfree_ok_ff <= rfree_ok_in;
      ridx_ff     <= ridx_in;
      rfree_ff    <= rfree_in;
      rcost_ff    <= rcost_in;
      rhop_ff     <= rhop_in;
      key_ff      <= key_in;
      kcost_ff    <= kcost_in;
      chg_ff      <= chg_in;
      full_ff     <= full_in;
   end

   `DVRT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "reset did not idle the sequencer")
   `DVRT_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "response shown for more than one cycle")
   `DVRT_ASSERT(a_busy_after_start, clock, reset, (start && !busy) |=> busy, "accepted transaction did not raise busy")
   `DVRT_ASSERT(a_found_lookup, clock, reset, (rsp_valid && rsp_data.found) |-> (req_ff.action == dvrt_pkg::ACT_LOOKUP), "found set outside a lookup")

endmodule

// ===== tb/dvrt_route_checker.sv =====
// route table checker: follows both channels and the csr port, predicts and compares responses
`timescale 1ns / 1ps

module dvrt_route_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  dvrt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  dvrt_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                mismatch_count,
   output int                pending_count
);

   localparam logic [2:0] ADDR_OWN_ID = 3'd0;
   localparam int RT_N = dvrt_pkg::ROUTE_ENTRIES;
   localparam int NB_N = dvrt_pkg::NEIGHBOR_ENTRIES;

   logic [15:0] own_id;
   logic [15:0] rt_dest [RT_N];
   logic [15:0] rt_cost [RT_N];
   logic [15:0] rt_hop  [RT_N];
   bit          rt_valid[RT_N];
   bit          rt_seen [RT_N];
   logic [15:0] nb_key  [NB_N];
   logic [15:0] nb_cost [NB_N];
   bit          nb_valid[NB_N];
   bit          vec_changed;
   dvrt_pkg::rsp_type expected_rsps[$];

   function automatic int route_index(logic [15:0] dest);
      for (int i = 0; i < RT_N; i++)
         if (rt_valid[i] && rt_dest[i] == dest) return i;
      return -1;
   endfunction

   function automatic int free_route_index();
      for (int i = 0; i < RT_N; i++)
         if (!rt_valid[i]) return i;
      return -1;
   endfunction

   function automatic int neighbour_index(logic [15:0] key);
      for (int i = 0; i < NB_N; i++)
         if (nb_valid[i] && nb_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void reconcile_routes(ref bit ch, ref bit full);
      int r;
      for (int n = 0; n < NB_N; n++) begin
         if (!nb_valid[n]) continue;
         r = route_index(nb_key[n]);
         if (r >= 0) begin
            if (rt_cost[r] > nb_cost[n]) begin
               rt_cost[r] = nb_cost[n];
               rt_hop[r]  = nb_key[n];
               ch = 1;
            end
         end else begin
            r = free_route_index();
            if (r < 0) begin
               full = 1;
            end else begin
               rt_dest[r] = nb_key[n];
               rt_cost[r] = nb_cost[n];
               rt_hop[r]  = nb_key[n];
               rt_valid[r] = 1;
               rt_seen[r] = 0;
               ch = 1;
            end
         end
      end
      for (r = 0; r < RT_N; r++)
         if (rt_valid[r] && neighbour_index(rt_hop[r]) < 0) begin
            rt_valid[r] = 0;
            rt_seen[r] = 0;
            ch = 1;
         end
   endfunction

   function automatic dvrt_pkg::rsp_type route_table_response(dvrt_pkg::req_type q);
      dvrt_pkg::rsp_type o;
      bit ch, full;
      int n, r;
      logic [16:0] sum;
      logic [15:0] nc;
      o = '0;
      ch = 0;
      full = 0;
      case (q.action)
         dvrt_pkg::ACT_VECTOR: begin
            n = neighbour_index(q.neighbor_id);
            if (n >= 0) begin
               if (q.node_id != own_id && q.cost != dvrt_pkg::COST_INF) begin
                  sum = {1'b0, nb_cost[n]} + {1'b0, q.cost};
                  nc = sum[16] ? dvrt_pkg::COST_INF : sum[15:0];
                  r = route_index(q.node_id);
                  if (r < 0) begin
                     r = free_route_index();
                     if (r < 0) begin
                        full = 1;
                     end else begin
                        rt_dest[r] = q.node_id;
                        rt_cost[r] = nc;
                        rt_hop[r]  = q.neighbor_id;
                        rt_valid[r] = 1;
                        rt_seen[r] = 1;
                        ch = 1;
                     end
                  end else if (nc < rt_cost[r] ||
                               (nc > rt_cost[r] && rt_hop[r] == q.neighbor_id)) begin
                     rt_cost[r] = nc;
                     rt_hop[r]  = q.neighbor_id;
                     ch = 1;
                  end
               end
               r = route_index(q.node_id);
               if (r >= 0) rt_seen[r] = 1;
            end
            vec_changed = vec_changed || ch;
            ch = 0;
            if (q.last) begin
               if (n >= 0)
                  for (r = 0; r < RT_N; r++)
                     if (rt_valid[r] && rt_hop[r] == q.neighbor_id &&
                         rt_dest[r] != q.neighbor_id && !rt_seen[r]) begin
                        rt_valid[r] = 0;
                        vec_changed = 1;
                     end
               ch = vec_changed;
               vec_changed = 0;
               foreach (rt_seen[i]) rt_seen[i] = 0;
            end
         end
         dvrt_pkg::ACT_LINK_COST: begin
            n = neighbour_index(q.neighbor_id);
            if (n < 0) begin
               for (n = 0; n < NB_N; n++)
                  if (!nb_valid[n]) break;
               if (n >= NB_N) begin
                  full = 1;
                  n = -1;
               end else begin
                  nb_valid[n] = 1;
                  nb_key[n] = q.neighbor_id;
               end
            end
            if (n >= 0) nb_cost[n] = q.cost;
            reconcile_routes(ch, full);
         end
         dvrt_pkg::ACT_LINK_DOWN: begin
            n = neighbour_index(q.neighbor_id);
            if (n >= 0) nb_valid[n] = 0;
            reconcile_routes(ch, full);
         end
         default: begin
            r = route_index(q.node_id);
            if (r >= 0) begin
               o.found = 1;
               o.next_hop = rt_hop[r];
               o.path_cost = rt_cost[r];
            end
         end
      endcase
      o.changed = ch;
      o.table_full = full;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      dvrt_pkg::rsp_type want;
      if (reset) begin
         own_id = '0;
         foreach (rt_valid[i]) begin
            rt_valid[i] = 0;
            rt_seen[i] = 0;
         end
         foreach (nb_valid[i]) nb_valid[i] = 0;
         vec_changed = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", 16'd0, 16'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 16'(rsp_data.found), 16'(want.found));
               if (rsp_data.next_hop !== want.next_hop)
                  report_mismatch("next_hop", rsp_data.next_hop, want.next_hop);
               if (rsp_data.path_cost !== want.path_cost)
                  report_mismatch("path_cost", rsp_data.path_cost, want.path_cost);
               if (rsp_data.changed !== want.changed)
                  report_mismatch("changed", 16'(rsp_data.changed), 16'(want.changed));
               if (rsp_data.table_full !== want.table_full)
                  report_mismatch("table_full", 16'(rsp_data.table_full),
                                  16'(want.table_full));
            end
         end
         if (start && !busy)
            expected_rsps = {expected_rsps, route_table_response(req_data)};
         if (psel && penable && pwrite && pready && paddr == ADDR_OWN_ID)
            own_id = pwdata[15:0];
      end
      pending_count = expected_rsps.size();
   end

endmodule

// ===== tb/tb_distance_vector_route_table_core.sv =====
// testbench top for the route table: stimulus, csr writes, watchdog and verdict
`timescale 1ns / 1ps

module tb_distance_vector_route_table_core;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS = 615;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   dvrt_pkg::req_type req_data;
   logic        rsp_valid;
   dvrt_pkg::rsp_type rsp_data;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          mismatch_count, pending_count;
   int          idle_pct, sent_count, quiet_cycles;

   distance_vector_route_table_core i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   dvrt_route_checker i_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatch_count, .pending_count
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL distance_vector_route_table_core");
         $finish;
      end
   end

   task automatic send(logic [1:0] act, logic [15:0] nb, logic [15:0] node,
                       logic [15:0] cost, logic last);
      if (busy) begin
         start <= 1'b0;
         while (busy) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{action: act, neighbor_id: nb, node_id: node, cost: cost, last: last};
      @(posedge clock);
      @(negedge clock);
      sent_count++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   endtask

   task automatic write_own_id(logic [15:0] value);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_neighbour();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'h0100 + 16'($urandom_range(0, 19));
      endcase
   endfunction

   function automatic logic [15:0] pick_node();
      case ($urandom_range(0, 11))
         0:       return 16'hFFFF;
         1:       return 16'($urandom);
         2:       return i_checker.own_id;
         default: return 16'h0100 + 16'($urandom_range(0, 89));
      endcase
   endfunction

   function automatic logic [15:0] pick_cost();
      case ($urandom_range(0, 9))
         0:       return dvrt_pkg::COST_INF;
         1:       return 16'($urandom);
         2:       return 16'hFFF0 + 16'($urandom_range(0, 14));
         default: return 16'($urandom_range(0, 40));
      endcase
   endfunction

   task automatic random_phase(int items);
      int len, kind;
      logic [15:0] nb;
      bit big_done;
      big_done = 0;
      while (items > 0) begin
         kind = $urandom_range(0, 99);
         if (!big_done && items < 300) begin
            nb = 16'h0100 + 16'($urandom_range(0, 19));
            for (int k = 0; k < 72; k++)
               send(dvrt_pkg::ACT_VECTOR, nb, 16'h0200 + 16'(k),
                    16'($urandom_range(0, 30)), k == 71);
            items -= 72;
            big_done = 1;
         end else if (kind < 55) begin
            nb = pick_neighbour();
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               send(dvrt_pkg::ACT_VECTOR, nb, pick_node(), pick_cost(), k == len - 1);
            items -= len;
         end else if (kind < 70) begin
            send(dvrt_pkg::ACT_LINK_COST, pick_neighbour(), 16'($urandom), pick_cost(),
                 1'($urandom));
            items--;
         end else if (kind < 80) begin
            send(dvrt_pkg::ACT_LINK_DOWN, pick_neighbour(), 16'($urandom), 16'($urandom),
                 1'($urandom));
            items--;
         end else if (kind < 95) begin
            send(dvrt_pkg::ACT_LOOKUP, 16'($urandom), pick_node(), 16'($urandom),
                 1'($urandom));
            items--;
         end else begin
            send(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom));
            items--;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_pct = 15;
      sent_count = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_own_id(16'h0105);
      send(dvrt_pkg::ACT_LOOKUP, 16'h0000, 16'h0101, 16'h0000, 1'b0);
      send(dvrt_pkg::ACT_LINK_COST, 16'h0101, 16'h0000, 16'd5, 1'b0);
      send(dvrt_pkg::ACT_LINK_COST, 16'h0102, 16'hFFFF, dvrt_pkg::COST_INF, 1'b1);
      send(dvrt_pkg::ACT_VECTOR, 16'h0101, 16'h0200, 16'd0, 1'b0);
      send(dvrt_pkg::ACT_VECTOR, 16'h0101, 16'h0105, 16'd3, 1'b0);
      send(dvrt_pkg::ACT_VECTOR, 16'h0101, 16'h0201, dvrt_pkg::COST_INF, 1'b0);
      send(dvrt_pkg::ACT_VECTOR, 16'h0102, 16'h0202, 16'd10, 1'b0);
      send(dvrt_pkg::ACT_VECTOR, 16'hBEEF, 16'h0203, 16'd1, 1'b1);
      send(dvrt_pkg::ACT_VECTOR, 16'h0101, 16'h0200, 16'd7, 1'b1);
      send(dvrt_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0200, 16'hFFFF, 1'b1);
      send(dvrt_pkg::ACT_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      send(dvrt_pkg::ACT_LINK_DOWN, 16'h0102, 16'h0000, 16'h0000, 1'b0);
      send(dvrt_pkg::ACT_LINK_DOWN, 16'h7777, 16'h0000, 16'h0000, 1'b0);
      for (int k = 0; k < 16; k++)
         send(dvrt_pkg::ACT_LINK_COST, 16'h0300 + 16'(k), 16'h0000, 16'(k), 1'b0);
      send(dvrt_pkg::ACT_VECTOR, 16'h0101, 16'h0200, 16'd1, 1'b1);

      write_own_id(16'hFFFF);
      random_phase(PHASE_ITEMS);
      idle_pct = 60;
      write_own_id(16'h0100 + 16'($urandom_range(0, 19)));
      random_phase(PHASE_ITEMS);
      idle_pct = 0;
      write_own_id(16'h0000);
      random_phase(PHASE_ITEMS);

      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS distance_vector_route_table_core");
      end else begin
         $display("FAIL distance_vector_route_table_core");
      end
      $finish;
   end

endmodule
